// File: sv/batched_matrix_multiply_assert.svh
// Assertion helpers used by batched_matrix_multiply.sv.
`ifndef BATCHED_MATRIX_MULTIPLY_ASSERT_SVH
`define BATCHED_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bmm_pkg.sv
`timescale 1ns / 1ps

package bmm_pkg;

    localparam int A_WORDS   = 1024;
    localparam int B_WORDS   = 1024;
    localparam int MAX_N     = 64;
    localparam int MAX_BATCH = 8;

    localparam int A_AW = $clog2(A_WORDS);
    localparam int B_AW = $clog2(B_WORDS);

    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 10;
    localparam int VALUE_W = 16;
    localparam int BATCH_W = 3;
    localparam int ROW_W   = 6;
    localparam int SUM_W   = 48;
    localparam int COL_W   = 6;
    localparam int PROD_W  = 2 * VALUE_W;

    localparam int BC_W  = 4;
    localparam int RM_W  = 7;
    localparam int IK_W  = 11;
    localparam int CN_W  = 7;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 3;

    localparam int ROWS_MAX  = 64;
    localparam int INNER_MAX = 1024;

    localparam int SPAN_W = RM_W + IK_W;
    localparam int END_W  = SPAN_W + BC_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_TRANSPOSED = 3'd4;

    typedef logic [A_AW-1:0] t_a_addr;
    typedef logic [B_AW-1:0] t_b_addr;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SPAN  = 7'b0000010,
        S_END   = 7'b0000100,
        S_BASE  = 7'b0001000,
        S_RUN   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

endpackage

// File: sv/batched_matrix_multiply.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Payload, lowest bit first
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: address, value, batch_index,
//                                             row_index; tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: sum, column; tlast: last;
//                                             tuser: status
// cfg       in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// A run item passes the setup states S_SPAN, S_END and S_BASE, then for each
// column does one multiply-accumulate per cycle through the shared 16x16
// multiplier, drains the pipeline and emits one result. A rejected run item
// goes from S_BASE straight to S_EMIT. Input is not ready until the run finishes.
// Reset is synchronous, active low; the element stores are not cleared.
// One output register: emitting a column waits while it is still full.

`include "batched_matrix_multiply_assert.svh"

module batched_matrix_multiply (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // address[9:0], value[25:10], batch_index[28:26], row_index[34:29], zero
    input  logic [bmm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [bmm_pkg::MODE_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sum[47:0], column[53:48], zero
    output logic [bmm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast,
    // status[0]
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmm_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [bmm_pkg::ADDR_W-1:0]  in_address;
    logic [bmm_pkg::VALUE_W-1:0] in_value;
    logic [bmm_pkg::BATCH_W-1:0] in_batch;
    logic [bmm_pkg::ROW_W-1:0]   in_row;
    logic                        in_acc;

    assign in_address = s_axis_tdata[9:0];
    assign in_value   = s_axis_tdata[25:10];
    assign in_batch   = s_axis_tdata[28:26];
    assign in_row     = s_axis_tdata[34:29];

    // configuration
    logic [bmm_pkg::BC_W-1:0] r_batch_count;
    logic [bmm_pkg::RM_W-1:0] r_rows_m;
    logic [bmm_pkg::IK_W-1:0] r_inner_k;
    logic [bmm_pkg::CN_W-1:0] r_cols_n;
    logic                     r_b_transposed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_count  <= bmm_pkg::BC_W'(1);
            r_rows_m       <= bmm_pkg::RM_W'(1);
            r_inner_k      <= bmm_pkg::IK_W'(1);
            r_cols_n       <= bmm_pkg::CN_W'(1);
            r_b_transposed <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmm_pkg::CFG_BATCH_COUNT:  r_batch_count  <= i_cfg_data[bmm_pkg::BC_W-1:0];
                bmm_pkg::CFG_ROWS_M:       r_rows_m       <= i_cfg_data[bmm_pkg::RM_W-1:0];
                bmm_pkg::CFG_INNER_K:      r_inner_k      <= i_cfg_data[bmm_pkg::IK_W-1:0];
                bmm_pkg::CFG_COLS_N:       r_cols_n       <= i_cfg_data[bmm_pkg::CN_W-1:0];
                bmm_pkg::CFG_B_TRANSPOSED: r_b_transposed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state
    bmm_pkg::t_state r_state, n_state;
    logic [bmm_pkg::BATCH_W-1:0] r_batch, n_batch;
    logic [bmm_pkg::ROW_W-1:0]   r_row, n_row;
    logic                        r_bad, n_bad;
    logic                        r_err, n_err;
    logic [bmm_pkg::SPAN_W-1:0]  r_a_span, n_a_span;
    logic [bmm_pkg::SPAN_W-1:0]  r_b_span, n_b_span;
    logic [bmm_pkg::SPAN_W-1:0]  r_row_off, n_row_off;
    logic [bmm_pkg::END_W-1:0]   r_a_end, n_a_end;
    logic [bmm_pkg::END_W-1:0]   r_b_end, n_b_end;
    bmm_pkg::t_a_addr            r_a_base, n_a_base;
    bmm_pkg::t_a_addr            r_a_ptr, n_a_ptr;
    bmm_pkg::t_b_addr            r_b_ptr, n_b_ptr;
    bmm_pkg::t_b_addr            r_b_col, n_b_col;
    logic [bmm_pkg::IK_W-1:0]    r_k_cnt, n_k_cnt;
    logic [bmm_pkg::COL_W-1:0]   r_col, n_col;

    // datapath
    logic                               r_rd_vld, r_pr_vld;
    logic signed [bmm_pkg::VALUE_W-1:0] r_a_q, r_b_q;
    logic signed [bmm_pkg::PROD_W-1:0]  r_prod;
    logic signed [bmm_pkg::SUM_W-1:0]   r_acc;
    logic                               acc_clr;

    // output register
    logic                        r_out_vld, n_out_vld;
    logic [bmm_pkg::SUM_W-1:0]   r_out_sum, n_out_sum;
    logic [bmm_pkg::COL_W-1:0]   r_out_col, n_out_col;
    logic                        r_out_last, n_out_last;
    logic                        r_out_status, n_out_status;

    // stores
    logic [bmm_pkg::VALUE_W-1:0] r_a_mem [bmm_pkg::A_WORDS];
    logic [bmm_pkg::VALUE_W-1:0] r_b_mem [bmm_pkg::B_WORDS];
    logic a_we, b_we;

    assign s_axis_tready = (r_state == bmm_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign a_we = in_acc && (s_axis_tuser == bmm_pkg::MODE_WRITE_A)
                  && (32'(in_address) < bmm_pkg::A_WORDS);
    assign b_we = in_acc && (s_axis_tuser == bmm_pkg::MODE_WRITE_B)
                  && (32'(in_address) < bmm_pkg::B_WORDS);

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_a_mem[bmm_pkg::t_a_addr'(32'(in_address))] <= in_value;
        end
        r_a_q <= r_a_mem[r_a_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_b_mem[bmm_pkg::t_b_addr'(32'(in_address))] <= in_value;
        end
        r_b_q <= r_b_mem[r_b_ptr];
    end

    logic                    range_bad;
    logic                    col_last;
    logic [bmm_pkg::END_W-1:0] a_off, b_off;

    assign range_bad = (r_batch_count == '0)
        || ({1'b0, r_batch_count} > (bmm_pkg::BC_W + 1)'(bmm_pkg::MAX_BATCH))
        || (r_rows_m == '0) || (r_rows_m > bmm_pkg::RM_W'(bmm_pkg::ROWS_MAX))
        || (r_inner_k == '0) || (r_inner_k > bmm_pkg::IK_W'(bmm_pkg::INNER_MAX))
        || (r_cols_n == '0)
        || ({1'b0, r_cols_n} > (bmm_pkg::CN_W + 1)'(bmm_pkg::MAX_N))
        || ({1'b0, r_batch} >= r_batch_count)
        || ({1'b0, r_row} >= r_rows_m);

    assign col_last = ({1'b0, r_col} + bmm_pkg::CN_W'(1)) == r_cols_n;
    assign a_off    = r_a_end - bmm_pkg::END_W'(r_a_span) + bmm_pkg::END_W'(r_row_off);
    assign b_off    = r_b_end - bmm_pkg::END_W'(r_b_span);

    always_comb begin
        n_state      = r_state;
        n_batch      = r_batch;
        n_row        = r_row;
        n_bad        = r_bad;
        n_err        = r_err;
        n_a_span     = r_a_span;
        n_b_span     = r_b_span;
        n_row_off    = r_row_off;
        n_a_end      = r_a_end;
        n_b_end      = r_b_end;
        n_a_base     = r_a_base;
        n_a_ptr      = r_a_ptr;
        n_b_ptr      = r_b_ptr;
        n_b_col      = r_b_col;
        n_k_cnt      = r_k_cnt;
        n_col        = r_col;
        acc_clr      = 1'b0;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_sum    = r_out_sum;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        case (r_state)
            bmm_pkg::S_IDLE: begin
                if (in_acc && (s_axis_tuser == bmm_pkg::MODE_RUN)) begin
                    n_batch = in_batch;
                    n_row   = in_row;
                    n_state = bmm_pkg::S_SPAN;
                end
            end
            bmm_pkg::S_SPAN: begin
                n_bad     = range_bad;
                n_a_span  = bmm_pkg::SPAN_W'(r_rows_m) * bmm_pkg::SPAN_W'(r_inner_k);
                n_b_span  = bmm_pkg::SPAN_W'(r_inner_k) * bmm_pkg::SPAN_W'(r_cols_n);
                n_row_off = bmm_pkg::SPAN_W'(r_row) * bmm_pkg::SPAN_W'(r_inner_k);
                n_state   = bmm_pkg::S_END;
            end
            bmm_pkg::S_END: begin
                n_a_end = (bmm_pkg::END_W'(r_batch) + bmm_pkg::END_W'(1))
                          * bmm_pkg::END_W'(r_a_span);
                n_b_end = (bmm_pkg::END_W'(r_batch) + bmm_pkg::END_W'(1))
                          * bmm_pkg::END_W'(r_b_span);
                n_state = bmm_pkg::S_BASE;
            end
            bmm_pkg::S_BASE: begin
                n_err    = r_bad || (r_a_end > bmm_pkg::END_W'(bmm_pkg::A_WORDS))
                           || (r_b_end > bmm_pkg::END_W'(bmm_pkg::B_WORDS));
                n_a_base = bmm_pkg::t_a_addr'(a_off);
                n_a_ptr  = bmm_pkg::t_a_addr'(a_off);
                n_b_ptr  = bmm_pkg::t_b_addr'(b_off);
                n_b_col  = bmm_pkg::t_b_addr'(b_off);
                n_k_cnt  = '0;
                n_col    = '0;
                acc_clr  = 1'b1;
                n_state  = n_err ? bmm_pkg::S_EMIT : bmm_pkg::S_RUN;
            end
            bmm_pkg::S_RUN: begin
                n_a_ptr = r_a_ptr + bmm_pkg::t_a_addr'(1);
                n_b_ptr = r_b_transposed ? r_b_ptr + bmm_pkg::t_b_addr'(1)
                                         : r_b_ptr + bmm_pkg::t_b_addr'(r_cols_n);
                n_k_cnt = r_k_cnt + bmm_pkg::IK_W'(1);
                if (n_k_cnt == r_inner_k) begin
                    n_state = bmm_pkg::S_DRAIN;
                end
            end
            bmm_pkg::S_DRAIN: begin
                if (!r_rd_vld && !r_pr_vld) begin
                    n_state = bmm_pkg::S_EMIT;
                end
            end
            bmm_pkg::S_EMIT: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_sum    = r_err ? '0 : r_acc;
                    n_out_col    = r_err ? '0 : r_col;
                    n_out_last   = r_err || col_last;
                    n_out_status = r_err;
                    if (r_err || col_last) begin
                        n_state = bmm_pkg::S_IDLE;
                    end else begin
                        n_col   = r_col + bmm_pkg::COL_W'(1);
                        n_k_cnt = '0;
                        n_a_ptr = r_a_base;
                        acc_clr = 1'b1;
                        if (!r_b_transposed) begin
                            n_b_col = r_b_col + bmm_pkg::t_b_addr'(1);
                            n_b_ptr = n_b_col;
                        end
                        n_state = bmm_pkg::S_RUN;
                    end
                end
            end
            default: n_state = bmm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bmm_pkg::S_IDLE;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_pr_vld  <= 1'b0;
            r_err     <= 1'b0;
            r_k_cnt   <= '0;
            r_col     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= (r_state == bmm_pkg::S_RUN);
            r_pr_vld  <= r_rd_vld;
            r_err     <= n_err;
            r_k_cnt   <= n_k_cnt;
            r_col     <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_batch      <= n_batch;
        r_row        <= n_row;
        r_bad        <= n_bad;
        r_a_span     <= n_a_span;
        r_b_span     <= n_b_span;
        r_row_off    <= n_row_off;
        r_a_end      <= n_a_end;
        r_b_end      <= n_b_end;
        r_a_base     <= n_a_base;
        r_a_ptr      <= n_a_ptr;
        r_b_ptr      <= n_b_ptr;
        r_b_col      <= n_b_col;
        r_out_sum    <= n_out_sum;
        r_out_col    <= n_out_col;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_prod       <= r_a_q * r_b_q;
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_pr_vld) begin
            r_acc <= r_acc + bmm_pkg::SUM_W'(r_prod);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(bmm_pkg::M_TDATA_W - bmm_pkg::SUM_W - bmm_pkg::COL_W){1'b0}},
                            r_out_col, r_out_sum};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;

    `BMM_ASSERT_NOW(a_k_in_range, i_clk, i_rst_n,
        r_state == bmm_pkg::S_RUN, r_k_cnt < r_inner_k, "k counter ran past inner_k")
    `BMM_ASSERT_NOW(a_emit_drained, i_clk, i_rst_n,
        r_state == bmm_pkg::S_EMIT && !r_err, !r_rd_vld && !r_pr_vld,
        "column emitted before accumulation finished")
    `BMM_ASSERT_NOW(a_error_is_last, i_clk, i_rst_n,
        r_out_vld && r_out_status, r_out_last && r_out_sum == '0,
        "error item not marked last or sum nonzero")
    `BMM_ASSERT_NEXT(a_error_skips_run, i_clk, i_rst_n,
        r_state == bmm_pkg::S_BASE && n_err, r_state == bmm_pkg::S_EMIT,
        "rejected request entered the multiply loop")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_GAP   = 16;
    localparam logic [bmm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [bmm_pkg::SUM_W-1:0] sum;
        logic [bmm_pkg::COL_W-1:0]        column;
        logic                             last;
        logic                             status;
    } t_row_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bmm_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [bmm_pkg::MODE_W-1:0]    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bmm_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;
    logic                          i_cfg_we = 1'b0;
    logic [bmm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bmm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    batched_matrix_multiply u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic signed [bmm_pkg::VALUE_W-1:0] a_mem [bmm_pkg::A_WORDS];
    logic signed [bmm_pkg::VALUE_W-1:0] b_mem [bmm_pkg::B_WORDS];
    bit                                 a_written [bmm_pkg::A_WORDS];
    bit                                 b_written [bmm_pkg::B_WORDS];
    logic [bmm_pkg::BC_W-1:0]           cfg_batches = bmm_pkg::BC_W'(1);
    logic [bmm_pkg::RM_W-1:0]           cfg_rows = bmm_pkg::RM_W'(1);
    logic [bmm_pkg::IK_W-1:0]           cfg_inner = bmm_pkg::IK_W'(1);
    logic [bmm_pkg::CN_W-1:0]           cfg_cols = bmm_pkg::CN_W'(1);
    logic                               cfg_b_transposed = 1'b0;

    t_row_result sums_due [$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  offer_up = 1'b0;
    int  hold_len = 0;
    int  hold_ticket = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  n_items = 0;
    int  n_runs = 0;
    int  n_rejects = 0;
    int  n_results = 0;
    int  n_settings = 0;
    int  n_fail = 0;
    int  n_cycles = 0;

    function automatic void add_due(input t_row_result r);
        sums_due = {sums_due, r};
    endfunction

    function automatic bit row_rejected(input logic [bmm_pkg::BATCH_W-1:0] bi,
                                        input logic [bmm_pkg::ROW_W-1:0] ri);
        int a_span, b_span;
        if (cfg_batches < 1 || cfg_batches > bmm_pkg::MAX_BATCH ||
            cfg_rows < 1 || cfg_rows > bmm_pkg::ROWS_MAX ||
            cfg_inner < 1 || cfg_inner > bmm_pkg::INNER_MAX ||
            cfg_cols < 1 || cfg_cols > bmm_pkg::MAX_N ||
            bi >= cfg_batches || ri >= cfg_rows)
            return 1'b1;
        a_span = int'(cfg_rows) * int'(cfg_inner);
        b_span = int'(cfg_inner) * int'(cfg_cols);
        return (int'(bi) + 1) * a_span > bmm_pkg::A_WORDS ||
               (int'(bi) + 1) * b_span > bmm_pkg::B_WORDS;
    endfunction

    function automatic void compute_row_sums(input logic [bmm_pkg::BATCH_W-1:0] bi,
                                             input logic [bmm_pkg::ROW_W-1:0] ri);
        int          inner, cols, a_base, b_base, b_at;
        longint      acc;
        t_row_result r;
        n_runs++;
        if (row_rejected(bi, ri)) begin
            r.sum = '0;
            r.column = '0;
            r.last = 1'b1;
            r.status = 1'b1;
            add_due(r);
            n_rejects++;
            return;
        end
        inner = int'(cfg_inner);
        cols = int'(cfg_cols);
        a_base = (int'(bi) * int'(cfg_rows) + int'(ri)) * inner;
        b_base = int'(bi) * inner * cols;
        for (int c = 0; c < cols; c++) begin
            acc = 0;
            for (int k = 0; k < inner; k++) begin
                b_at = cfg_b_transposed ? b_base + c * inner + k : b_base + k * cols + c;
                acc += longint'(a_mem[a_base + k]) * longint'(b_mem[b_at]);
            end
            r.sum = acc[bmm_pkg::SUM_W-1:0];
            r.column = bmm_pkg::COL_W'(c);
            r.last = (c == cols - 1);
            r.status = 1'b0;
            add_due(r);
        end
    endfunction

    function automatic logic [bmm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return bmm_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_below(input int unsigned n, input int unsigned top);
        return $urandom_range((n == 0) ? 0 : ((n - 1 > top) ? top : n - 1));
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    t_row_result got;
    assign got = {m_axis_tdata[bmm_pkg::SUM_W-1:0],
                  m_axis_tdata[bmm_pkg::SUM_W +: bmm_pkg::COL_W], m_axis_tlast,
                  m_axis_tuser};

    always @(posedge i_clk) begin
        t_row_result due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sums_due.size() == 0) begin
                $display("%0t: expected no result, got sum %0d column %0d last %0b status %0b",
                         $time, got.sum, got.column, got.last, got.status);
                n_fail++;
            end else begin
                due = sums_due.pop_front();
                n_results++;
                if (got !== due) begin
                    $display("%0t: result mismatch, expected sum %0d column %0d last %0b status %0b",
                             $time, due.sum, due.column, due.last, due.status);
                    $display("%0t:                  got sum %0d column %0d last %0b status %0b",
                             $time, got.sum, got.column, got.last, got.status);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time, sums_due.size());
            $display("** batched_matrix_multiply: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic [bmm_pkg::MODE_W-1:0] mode,
                             input logic [bmm_pkg::ADDR_W-1:0] addr,
                             input logic [bmm_pkg::VALUE_W-1:0] value,
                             input logic [bmm_pkg::BATCH_W-1:0] bi,
                             input logic [bmm_pkg::ROW_W-1:0] ri);
        while ($urandom_range(99) < send_idle_pct) begin
            if (offer_up) begin
                s_axis_tvalid <= 1'b0;
                offer_up = 1'b0;
            end
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= bmm_pkg::S_TDATA_W'({ri, bi, value, addr});
        offer_up = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
        case (mode)
            bmm_pkg::MODE_WRITE_A: begin
                a_mem[addr] = value;
                a_written[addr] = 1'b1;
            end
            bmm_pkg::MODE_WRITE_B: begin
                b_mem[addr] = value;
                b_written[addr] = 1'b1;
            end
            bmm_pkg::MODE_RUN: compute_row_sums(bi, ri);
            default: ;
        endcase
    endtask

    task automatic write_a(input logic [bmm_pkg::ADDR_W-1:0] addr,
                           input logic [bmm_pkg::VALUE_W-1:0] value);
        send_item(bmm_pkg::MODE_WRITE_A, addr, value, bmm_pkg::BATCH_W'($urandom),
                  bmm_pkg::ROW_W'($urandom));
    endtask

    task automatic write_b(input logic [bmm_pkg::ADDR_W-1:0] addr,
                           input logic [bmm_pkg::VALUE_W-1:0] value);
        send_item(bmm_pkg::MODE_WRITE_B, addr, value, bmm_pkg::BATCH_W'($urandom),
                  bmm_pkg::ROW_W'($urandom));
    endtask

    task automatic run_row(input logic [bmm_pkg::BATCH_W-1:0] bi,
                           input logic [bmm_pkg::ROW_W-1:0] ri);
        send_item(bmm_pkg::MODE_RUN, bmm_pkg::ADDR_W'($urandom), bmm_pkg::VALUE_W'($urandom),
                  bi, ri);
    endtask

    // Load every element the row will read that has not been loaded yet.
    task automatic fill_for_row(input logic [bmm_pkg::BATCH_W-1:0] bi,
                                input logic [bmm_pkg::ROW_W-1:0] ri);
        int inner, span, a_base, b_base;
        if (row_rejected(bi, ri))
            return;
        inner = int'(cfg_inner);
        span = inner * int'(cfg_cols);
        a_base = (int'(bi) * int'(cfg_rows) + int'(ri)) * inner;
        b_base = int'(bi) * span;
        for (int k = 0; k < inner; k++)
            if (!a_written[a_base + k])
                write_a(bmm_pkg::ADDR_W'(a_base + k), pick_value());
        for (int j = 0; j < span; j++)
            if (!b_written[b_base + j])
                write_b(bmm_pkg::ADDR_W'(b_base + j), pick_value());
    endtask

    task automatic request_row(input logic [bmm_pkg::BATCH_W-1:0] bi,
                               input logic [bmm_pkg::ROW_W-1:0] ri);
        fill_for_row(bi, ri);
        run_row(bi, ri);
    endtask

    task automatic wait_drained();
        if (offer_up) begin
            s_axis_tvalid <= 1'b0;
            offer_up = 1'b0;
            @(posedge i_clk);
        end
        while (sums_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [bmm_pkg::CFG_IDX_W-1:0] index,
                           input logic [bmm_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input int unsigned batches, rows, inner, cols,
                              input bit transposed);
        put_reg(bmm_pkg::CFG_BATCH_COUNT, bmm_pkg::CFG_W'(batches));
        put_reg(bmm_pkg::CFG_ROWS_M, bmm_pkg::CFG_W'(rows));
        put_reg(bmm_pkg::CFG_INNER_K, bmm_pkg::CFG_W'(inner));
        put_reg(bmm_pkg::CFG_COLS_N, bmm_pkg::CFG_W'(cols));
        put_reg(bmm_pkg::CFG_B_TRANSPOSED, bmm_pkg::CFG_W'(transposed));
        i_cfg_we <= 1'b0;
        cfg_batches = bmm_pkg::BC_W'(batches);
        cfg_rows = bmm_pkg::RM_W'(rows);
        cfg_inner = bmm_pkg::IK_W'(inner);
        cfg_cols = bmm_pkg::CN_W'(cols);
        cfg_b_transposed = transposed;
        n_settings++;
    endtask

    task automatic test_directed_rows();
        write_regs(1, 2, 2, 2, 1'b0);
        write_a(10'd0, 16'h8000);
        write_a(10'd1, 16'h7fff);
        write_a(10'd2, 16'hffff);
        write_a(10'd3, 16'h0001);
        write_b(10'd0, 16'h8000);
        write_b(10'd1, 16'h7fff);
        write_b(10'd2, 16'h8000);
        write_b(10'd3, 16'hffff);
        write_a(bmm_pkg::ADDR_W'(bmm_pkg::A_WORDS - 1), 16'h7fff);
        write_b(bmm_pkg::ADDR_W'(bmm_pkg::B_WORDS - 1), 16'h8000);
        run_row(3'd0, 6'd0);
        run_row(3'd0, 6'd1);
        send_item(MODE_UNUSED, bmm_pkg::ADDR_W'($urandom), bmm_pkg::VALUE_W'($urandom),
                  bmm_pkg::BATCH_W'($urandom), bmm_pkg::ROW_W'($urandom));
        wait_drained();
        write_regs(1, 2, 2, 2, 1'b1);
        run_row(3'd0, 6'd0);
        run_row(3'd0, 6'd1);
    endtask

    task automatic test_bad_requests();
        int unsigned regs [4];
        int unsigned just_over [4] = '{9, 65, 1025, 65};
        int unsigned all_ones [4] = '{15, 127, 2047, 127};
        run_row(3'd1, 6'd0);
        run_row(3'd0, 6'd2);
        run_row(3'd7, 6'd63);
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
                regs = '{1, 1, 1, 1};
                regs[r] = (j == 0) ? 0 : (j == 1) ? just_over[r] : all_ones[r];
                wait_drained();
                write_regs(regs[0], regs[1], regs[2], regs[3], 1'b0);
                run_row(3'd0, 6'd0);
            end
        end
        // A batch past the end of the A store, then of the B store.
        wait_drained();
        write_regs(8, 64, 16, 1, 1'b0);
        run_row(3'd1, 6'd0);
        wait_drained();
        write_regs(8, 1, 4, 64, 1'b1);
        run_row(3'd4, 6'd0);
    endtask

    task automatic test_random_phase(input int idle, input int stall);
        int unsigned                 batches, rows, inner, cols, pick;
        bit                          transposed;
        logic [bmm_pkg::BATCH_W-1:0] bi;
        logic [bmm_pkg::ROW_W-1:0]   ri;
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (2) begin
            wait_drained();
            if ($urandom_range(4) == 0) begin
                batches = $urandom_range(1) ? $urandom_range(9, 15) : 0;
                rows = $urandom_range(127);
                inner = $urandom_range(2047);
                cols = $urandom_range(127);
            end else begin
                batches = $urandom_range(1, 4);
                rows = $urandom_range(1, 4);
                inner = $urandom_range(1, 3);
                cols = $urandom_range(1, 4);
            end
            transposed = $urandom_range(1);
            write_regs(batches, rows, inner, cols, transposed);
            repeat (9) begin
                pick = $urandom_range(99);
                bi = bmm_pkg::BATCH_W'(pick_below(cfg_batches, 7));
                ri = bmm_pkg::ROW_W'(pick_below(cfg_rows, 63));
                if (pick < 60)
                    request_row(bi, ri);
                else if (pick < 72)
                    write_a(bmm_pkg::ADDR_W'(pick_below(int'(cfg_batches) * int'(cfg_rows) *
                                                        int'(cfg_inner), 1023)), pick_value());
                else if (pick < 84)
                    write_b(bmm_pkg::ADDR_W'(pick_below(int'(cfg_batches) * int'(cfg_inner) *
                                                        int'(cfg_cols), 1023)), pick_value());
                else if (pick < 92)
                    request_row(bmm_pkg::BATCH_W'($urandom), bmm_pkg::ROW_W'($urandom));
                else
                    send_item(MODE_UNUSED, bmm_pkg::ADDR_W'($urandom),
                              bmm_pkg::VALUE_W'($urandom), bmm_pkg::BATCH_W'($urandom),
                              bmm_pkg::ROW_W'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        stall_pct = 0;
        write_regs(1, 4, 1, 64, 1'b0);
        for (int r = 0; r < 4; r++)
            fill_for_row(3'd0, bmm_pkg::ROW_W'(r));
        hold_len = 1500;
        hold_ticket++;
        for (int r = 0; r < 4; r++)
            run_row(3'd0, bmm_pkg::ROW_W'(r));
        wait_drained();
    endtask

    task automatic test_store_edges();
        wait_drained();
        send_idle_pct = 0;
        stall_pct = 0;
        write_regs(8, 64, 2, 1, 1'b0);
        request_row(3'd7, 6'd63);
        request_row(3'd0, 6'd0);
        wait_drained();
        write_regs(8, 64, 2, 1, 1'b1);
        request_row(3'd7, 6'd63);
        request_row(3'd7, 6'd0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_rows();
        test_bad_requests();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(88, 0);
        test_random_phase(0, 88);
        test_random_phase(18, 18);
        test_store_edges();
        wait_drained();
        $display("Sent %0d items, %0d row requests (%0d rejected), over %0d register settings.",
                 n_items, n_runs, n_rejects, n_settings);
        $display("Checked %0d results in %0d cycles, %0d mismatches.",
                 n_results, n_cycles, n_fail);
        if (n_fail == 0)
            $display("** batched_matrix_multiply: PASSED **");
        else
            $display("** batched_matrix_multiply: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/bmm_pkg.sv
sv/batched_matrix_multiply.sv
sim/tb.sv
